### src/biquad_decimate_by_four_unit_defines.svh
// Assertion macros shared by the checker files of the biquad decimator.
`ifndef BIQUAD_DECIMATE_BY_FOUR_UNIT_DEFINES_SVH
`define BIQUAD_DECIMATE_BY_FOUR_UNIT_DEFINES_SVH

// Same-cycle implication, quiet while reset is held.
`define BQD4_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is held.
`define BQD4_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold on the cycle after any cycle in which reset is held.
`define BQD4_ASSERT_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error(msg);

`endif

### src/bqd4_pkg.sv
// Shared types, register codes and constants of the biquad decimator.
package bqd4_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int LEN_W     = 13;
  localparam int POS_W     = 12;
  localparam int CFG_IDX_W = 3;
  localparam int QBITS     = 14;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int ACC_W     = PROD_W + 3;
  localparam int MAX_FRAME = 4096;
  localparam int DECIM     = 4;
  localparam int DEC_SH    = 2;

  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_FRAME);
  localparam logic [LEN_W-1:0] LEN_ONE   = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_DECIM = LEN_W'(DECIM);
  localparam logic [LEN_W-1:0] LEN_MASK  = ~LEN_W'(DECIM - 1);

  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1 << (QBITS - 1));
  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO   = -ACC_W'(32768);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0   = 3'd0,
    REG_B1   = 3'd1,
    REG_B2   = 3'd2,
    REG_A1   = 3'd3,
    REG_A2   = 3'd4,
    REG_FLEN = 3'd5
  } cfg_reg_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_val_t;

  // Coefficient set handed to the filter datapath
  typedef struct packed {
    coef_val_t b0;
    coef_val_t b1;
    coef_val_t b2;
    coef_val_t a1;
    coef_val_t a2;
  } coef_t;

  localparam coef_t COEF_RESET = '{
    b0: COEF_W'(4799),
    b1: COEF_W'(9598),
    b2: COEF_W'(4799),
    a1: COEF_W'(0),
    a2: COEF_W'(2812)
  };
  localparam logic [LEN_W-1:0] FLEN_RESET = LEN_W'(512);

endpackage

### src/bqd4_filter.sv
// Direct-form-I biquad datapath: five products, sum, round half up, saturate.
module bqd4_filter (
  input  bqd4_pkg::coef_t   coef,
  input  bqd4_pkg::sample_t x0,
  input  bqd4_pkg::sample_t x1,
  input  bqd4_pkg::sample_t x2,
  input  bqd4_pkg::sample_t y1,
  input  bqd4_pkg::sample_t y2,
  output bqd4_pkg::sample_t y0
);
  import bqd4_pkg::*;

  logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [ACC_W-1:0]  acc_int;

  // Form the products
  assign p_b0 = coef.b0 * x0;
  assign p_b1 = coef.b1 * x1;
  assign p_b2 = coef.b2 * x2;
  assign p_a1 = coef.a1 * y1;
  assign p_a2 = coef.a2 * y2;

  // Sum with the feedback terms subtracted
  assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
             - ACC_W'(p_a1) - ACC_W'(p_a2);

  // Round half toward plus infinity, drop the fraction bits
  assign acc_rnd = acc + ACC_HALF;
  assign acc_int = acc_rnd >>> QBITS;

  // Clamp to the sample range
  always_comb begin
    if (acc_int > SAT_HI) begin
      y0 = sample_t'(SAT_HI[SAMPLE_W-1:0]);
    end else if (acc_int < SAT_LO) begin
      y0 = sample_t'(SAT_LO[SAMPLE_W-1:0]);
    end else begin
      y0 = sample_t'(acc_int[SAMPLE_W-1:0]);
    end
  end

endmodule

### src/biquad_decimate_by_four_unit.sv
// Top level of the biquad low-pass decimator by four.
// Each request carries one signed 16-bit sample. It is latched into an input
// register, filtered in the following cycle by a combinational biquad (five
// 16x16 products, sum, round, saturate) and, at frame positions 0, 4, 8, ...
// below the usable frame length, written into the output register; out_tlast
// marks the last output of a frame. One sample is taken per cycle; the
// filter feedback closes combinationally, and an output waiting in the
// output register stalls the input only when the next sample also emits.
// An emitted sample passes both registers in turn. Frame position and history
// restart at each frame start. Configuration writes are taken every cycle.
module biquad_decimate_by_four_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // input samples
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [15:0]                        in_tdata,   // [15:0] sample_in
  // filtered, decimated samples
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [15:0]                        out_tdata,  // [15:0] sample_out
  output logic                               out_tlast,
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bqd4_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bqd4_pkg::COEF_W-1:0]        cfg_data
);
  import bqd4_pkg::*;

  coef_t              coef_r, coef_nxt;
  logic [LEN_W-1:0]   flen_r, flen_nxt;
  logic               s1_valid_r, s1_valid_nxt;
  sample_t            s1_x_r, s1_x_nxt;
  sample_t            xh1_r, xh1_nxt, xh2_r, xh2_nxt;
  sample_t            yh1_r, yh1_nxt, yh2_r, yh2_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               out_valid_r, out_valid_nxt;
  sample_t            out_data_r, out_data_nxt;
  logic               out_last_r, out_last_nxt;

  logic [LEN_W-1:0]   len_eff;
  logic [LEN_W-1:0]   usable;
  logic [POS_W-1:0]   pos_cur;
  logic [LEN_W-1:0]   pos_ext;
  logic [LEN_W-1:0]   pos_inc;
  logic               frame_start;
  logic               emit;
  logic               last;
  logic               out_free;
  logic               s1_adv;
  sample_t            hx1, hx2, hy1, hy2;
  sample_t            y_new;

  assign cfg_ready = 1'b1;

  // Decode register writes
  always_comb begin
    coef_nxt = coef_r;
    flen_nxt = flen_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_B0:   coef_nxt.b0 = coef_val_t'(cfg_data);
        REG_B1:   coef_nxt.b1 = coef_val_t'(cfg_data);
        REG_B2:   coef_nxt.b2 = coef_val_t'(cfg_data);
        REG_A1:   coef_nxt.a1 = coef_val_t'(cfg_data);
        REG_A2:   coef_nxt.a2 = coef_val_t'(cfg_data);
        REG_FLEN: flen_nxt    = cfg_data[LEN_W-1:0];
        default:  ;
      endcase
    end
  end

  // Effective frame length and the part that yields whole decimation groups
  always_comb begin
    if (flen_r == '0) begin
      len_eff = LEN_ONE;
    end else if (flen_r > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = flen_r;
    end
  end
  assign usable = len_eff & LEN_MASK;

  // Frame position of the sample in the filter stage
  assign pos_cur     = ({1'b0, pos_r} >= len_eff) ? '0 : pos_r;
  assign pos_ext     = {1'b0, pos_cur};
  assign pos_inc     = pos_ext + LEN_ONE;
  assign frame_start = (pos_cur == '0);
  assign emit        = (pos_ext < usable) && (pos_cur[DEC_SH-1:0] == '0);
  assign last        = ((pos_ext + LEN_DECIM) == usable);

  // Clear the history at frame start
  assign hx1 = frame_start ? '0 : xh1_r;
  assign hx2 = frame_start ? '0 : xh2_r;
  assign hy1 = frame_start ? '0 : yh1_r;
  assign hy2 = frame_start ? '0 : yh2_r;

  bqd4_filter u_filter (
    .coef (coef_r),
    .x0   (s1_x_r),
    .x1   (hx1),
    .x2   (hx2),
    .y1   (hy1),
    .y2   (hy2),
    .y0   (y_new)
  );

  // Advance the filter stage unless its result has nowhere to go
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!emit || out_free);
  assign in_tready = !s1_valid_r || s1_adv;

  // Input register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_x_nxt     = s1_x_r;
    if (in_tready) begin
      s1_valid_nxt = in_tvalid;
      s1_x_nxt     = sample_t'(in_tdata);
    end
  end

  // History and frame position
  always_comb begin
    xh1_nxt = xh1_r;
    xh2_nxt = xh2_r;
    yh1_nxt = yh1_r;
    yh2_nxt = yh2_r;
    pos_nxt = pos_r;
    if (s1_adv) begin
      xh1_nxt = s1_x_r;
      xh2_nxt = hx1;
      yh1_nxt = y_new;
      yh2_nxt = hy1;
      pos_nxt = (pos_inc >= len_eff) ? '0 : pos_inc[POS_W-1:0];
    end
  end

  // Output register: load on an emitting advance, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (s1_adv && emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = y_new;
      out_last_nxt  = last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r      <= COEF_RESET;
      flen_r      <= FLEN_RESET;
      s1_valid_r  <= 1'b0;
      xh1_r       <= '0;
      xh2_r       <= '0;
      yh1_r       <= '0;
      yh2_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      coef_r      <= coef_nxt;
      flen_r      <= flen_nxt;
      s1_valid_r  <= s1_valid_nxt;
      xh1_r       <= xh1_nxt;
      xh2_r       <= xh2_nxt;
      yh1_r       <= yh1_nxt;
      yh2_r       <= yh2_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s1_x_r     <= s1_x_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

### src/bqd4_checker.sv
// Port-level checks of the biquad decimator, bound to its top level.
`include "biquad_decimate_by_four_unit_defines.svh"

module bqd4_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  logic out_held;

  // Output request waiting on the receiver
  assign out_held = out_tvalid && !out_tready;

  // A held output request stays up
  `BQD4_ASSERT_NEXT(a_out_hold, out_held, out_tvalid, "output request dropped")

  // A held output request keeps its sample
  `BQD4_ASSERT_NEXT(a_data_stable, out_held, $stable(out_tdata), "output data changed in stall")

  // A held output request keeps its frame flag
  `BQD4_ASSERT_NEXT(a_last_stable, out_held, $stable(out_tlast), "output last changed in stall")

  // Reset empties the output register
  `BQD4_ASSERT_RESET(a_rst_empty, !out_tvalid, "output valid after reset")

  // With no result pending the input side never stalls
  `BQD4_ASSERT_SAME(a_in_free, !out_tvalid, in_tready, "input stalled with empty output")

endmodule

bind biquad_decimate_by_four_unit bqd4_checker u_bqd4_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

### bench/tb_biquad_decimate_by_four_unit.sv
// Self-checking bench for the biquad low-pass decimator by four.
module tb_biquad_decimate_by_four_unit;
  import bqd4_pkg::*;

  // Indexes that address no register; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  localparam int RANDOM_PHASES   = 11;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int SETTLE_CYCLES   = 8;
  localparam int IDLE_LIMIT      = 4000;

  typedef struct packed {
    sample_t value;
    logic    last;
  } decimated_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0]          data;
    logic                 typed;
    logic [15:0]          exp_value;
    logic                 exp_last;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;     // [15:0] sample_in
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;         // [15:0] sample_out
  logic out_tlast;                // frame_last
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;

  // Filter model state
  coef_t           coef_set;
  logic [LEN_W-1:0] frame_len_cfg;
  sample_t         tap_x1, tap_x2, tap_y1, tap_y2;
  int              frame_pos;

  decimated_t decimated_q[$];
  decimated_t exp_head;
  row_t       directed_rows[$];
  int         error_count = 0;
  int         burst_left = 0;
  int         idle_cycles = 0;
  int         pattern_left = 0;
  logic [15:0] ready_pattern = '1;
  logic       cfg_busy = 1'b0;

  biquad_decimate_by_four_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Update the model's registers on an accepted write
  task automatic apply_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    case (idx)
      REG_B0:   coef_set.b0 = data;
      REG_B1:   coef_set.b1 = data;
      REG_B2:   coef_set.b2 = data;
      REG_A1:   coef_set.a1 = data;
      REG_A2:   coef_set.a2 = data;
      REG_FLEN: frame_len_cfg = data[LEN_W-1:0];
      default: ;
    endcase
  endtask

  // Run one sample through the biquad and the decimation rule
  task automatic biquad_predict(input sample_t x, output logic emits, output sample_t y,
                                output logic last);
    int     len;
    int     usable;
    int     p;
    longint acc;
    longint r;
    len = int'(frame_len_cfg);
    if (len == 0) len = 1;
    if (len > MAX_FRAME) len = MAX_FRAME;
    usable = (len / DECIM) * DECIM;
    // a shortened frame restarts here
    if (frame_pos >= len) frame_pos = 0;
    p = frame_pos;
    if (p == 0) begin
      tap_x1 = '0;
      tap_x2 = '0;
      tap_y1 = '0;
      tap_y2 = '0;
    end
    acc = longint'(signed'(coef_set.b0)) * longint'(x)
        + longint'(signed'(coef_set.b1)) * longint'(tap_x1)
        + longint'(signed'(coef_set.b2)) * longint'(tap_x2)
        - longint'(signed'(coef_set.a1)) * longint'(tap_y1)
        - longint'(signed'(coef_set.a2)) * longint'(tap_y2);
    // round half up, then clamp to 16 bits
    r = (acc + (64'sd1 <<< (QBITS - 1))) >>> QBITS;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    y = sample_t'(r);
    tap_x2 = tap_x1;
    tap_x1 = x;
    tap_y2 = tap_y1;
    tap_y1 = y;
    emits = (p < usable) && (p % DECIM == 0);
    last = (p + DECIM == usable);
    p++;
    frame_pos = (p >= len) ? 0 : p;
  endtask

  // Release the write channel once a series of register writes is over
  task automatic end_cfg_series();
    if (cfg_busy) begin
      cfg_valid <= 1'b0;
      cfg_busy = 1'b0;
    end
  endtask

  // Drop valid and hold until every expected output is out and the pipe is empty
  task automatic settle();
    end_cfg_series();
    in_tvalid <= 1'b0;
    while (decimated_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; the first write of a series waits for an idle block
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    if (!cfg_busy) settle();
    cfg_busy = 1'b1;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, data);
  endtask

  // Insert a random gap at the end of each burst
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      end_cfg_series();
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Present one sample request and queue what it should produce
  task automatic send_sample(input sample_t x, input logic typed, input logic [15:0] typed_value,
                             input logic typed_last);
    logic    emits;
    sample_t y;
    logic    last;
    end_cfg_series();
    in_tvalid <= 1'b1;
    in_tdata  <= x;
    do @(posedge clk); while (!in_tready);
    biquad_predict(x, emits, y, last);
    if (typed) decimated_q.push_back('{value: typed_value, last: typed_last});
    else if (emits) decimated_q.push_back('{value: y, last: last});
  endtask

  function automatic logic [15:0] pick_coefficient(input int style, input logic [15:0] dflt);
    int v;
    case (style)
      0: return dflt;
      1: return 16'($urandom);
      2: begin
        case ($urandom_range(0, 2))
          0: return 16'h7FFF;
          1: return 16'h8000;
          default: return 16'h0000;
        endcase
      end
      default: begin
        v = $urandom_range(0, 16383) - 8192;
        return v[15:0];
      end
    endcase
  endfunction

  function automatic row_t sample_row(input logic [15:0] x);
    return '{is_cfg: 1'b0, idx: '0, data: x, typed: 1'b0, exp_value: '0, exp_last: 1'b0};
  endfunction

  function automatic row_t checked_row(input logic [15:0] x, input logic [15:0] v, input logic l);
    return '{is_cfg: 1'b0, idx: '0, data: x, typed: 1'b1, exp_value: v, exp_last: l};
  endfunction

  function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] d);
    return '{is_cfg: 1'b1, idx: idx, data: d, typed: 1'b0, exp_value: '0, exp_last: 1'b0};
  endfunction

  // Compare outputs and stall the receiver on a rotating pattern
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (decimated_q.size() == 0) begin
        $display("%0t: output with none expected, got %0d last %0b", $time,
                 $signed(out_tdata), out_tlast);
        error_count++;
      end else begin
        exp_head = decimated_q.pop_front();
        if (out_tdata !== exp_head.value) begin
          $display("%0t: sample_out expected %0d, got %0d", $time, exp_head.value,
                   $signed(out_tdata));
          error_count++;
        end
        if (out_tlast !== exp_head.last) begin
          $display("%0t: frame_last expected %0b, got %0b", $time, exp_head.last, out_tlast);
          error_count++;
        end
      end
    end
    if (pattern_left == 0) begin
      pattern_left = $urandom_range(32, 256);
      case ($urandom_range(0, 3))
        0: ready_pattern = '1;
        1: ready_pattern = 16'($urandom);
        2: ready_pattern = (16'h0001 << $urandom_range(0, 15)) | 16'h0100;
        default: ready_pattern = 16'($urandom) | 16'($urandom);
      endcase
    end else begin
      pattern_left--;
    end
    ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
    out_tready <= ready_pattern[0];
  end

  // Watchdog: end the run when no handshake completes for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          drain_at;
    int          coef_style;
    logic [15:0] flen;
    sample_t     x;

    coef_set      = COEF_RESET;
    frame_len_cfg = FLEN_RESET;
    tap_x1 = '0;
    tap_x2 = '0;
    tap_y1 = '0;
    tap_y2 = '0;
    frame_pos = 0;

    // Directed table: reset values, unity gain, gain of minus two, odd frame lengths
    directed_rows = '{
      checked_row(16'h0000, 16'h0000, 1'b0),
      sample_row(16'h7FFF),
      sample_row(16'h8000),
      sample_row(16'h0001),
      cfg_row(REG_B0, 16'h4000),
      cfg_row(REG_B1, 16'h0000),
      cfg_row(REG_B2, 16'h0000),
      cfg_row(REG_A1, 16'h0000),
      cfg_row(REG_A2, 16'h0000),
      cfg_row(REG_FLEN, 16'h0004),
      checked_row(16'h7FFF, 16'h7FFF, 1'b1),
      sample_row(16'h0064),
      sample_row(16'hFFFB),
      sample_row(16'h0007),
      checked_row(16'h8000, 16'h8000, 1'b1),
      sample_row(16'h0003),
      // zero length acts as one: no output
      cfg_row(REG_B0, 16'h8000),
      cfg_row(REG_FLEN, 16'h0000),
      sample_row(16'h8000),
      sample_row(16'h04D2),
      // frame shorter than the decimation factor
      cfg_row(REG_FLEN, 16'h0003),
      sample_row(16'h0001),
      sample_row(16'h0002),
      sample_row(16'h0003),
      // oversized length clamps to the maximum; unused indexes are ignored
      cfg_row(REG_FLEN, 16'hFFFF),
      cfg_row(REG_UNUSED_LO, 16'h1234),
      cfg_row(REG_UNUSED_HI, 16'hFFFF),
      checked_row(16'h8000, 16'h7FFF, 1'b0),
      sample_row(16'h7FFF),
      // shorten below the current position: the next sample opens a frame
      cfg_row(REG_FLEN, 16'h0002),
      sample_row(16'h0005),
      // coefficient extremes on every tap
      cfg_row(REG_B1, 16'h7FFF),
      cfg_row(REG_B2, 16'h8000),
      cfg_row(REG_A1, 16'h8000),
      cfg_row(REG_A2, 16'h7FFF),
      cfg_row(REG_FLEN, 16'h0008),
      sample_row(16'h7FFF),
      sample_row(16'h8000),
      sample_row(16'h7FFF),
      sample_row(16'h8000),
      sample_row(16'h0000)
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        cfg_write(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        pace_sender();
        send_sample(directed_rows[i].data, directed_rows[i].typed,
                    directed_rows[i].exp_value, directed_rows[i].exp_last);
      end
    end

    // Random phases, each under a fresh register setting
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      coef_style = $urandom_range(0, 3);
      cfg_write(REG_B0, pick_coefficient(coef_style, COEF_RESET.b0));
      cfg_write(REG_B1, pick_coefficient(coef_style, COEF_RESET.b1));
      cfg_write(REG_B2, pick_coefficient(coef_style, COEF_RESET.b2));
      cfg_write(REG_A1, pick_coefficient(coef_style, COEF_RESET.a1));
      cfg_write(REG_A2, pick_coefficient(coef_style, COEF_RESET.a2));
      case ($urandom_range(0, 9))
        0: flen = 16'h0000;
        1: flen = 16'(MAX_FRAME);
        2: flen = 16'hFFFF;
        3: flen = 16'($urandom);
        4: flen = 16'($urandom_range(1, 3));
        default: flen = 16'($urandom_range(4, 40));
      endcase
      cfg_write(REG_FLEN, flen);
      if ($urandom_range(0, 3) == 0) begin
        cfg_write(($urandom_range(0, 1) != 0) ? REG_UNUSED_HI : REG_UNUSED_LO, 16'($urandom));
      end

      drain_at = $urandom_range(0, ITEMS_PER_PHASE - 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // hold off until the block has delivered everything
        if (n == drain_at) settle();
        pace_sender();
        case ($urandom_range(0, 7))
          0: x = 16'h7FFF;
          1: x = 16'h8000;
          2: x = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
          3, 4: x = 16'($urandom_range(0, 511) - 256);
          default: x = 16'($urandom);
        endcase
        send_sample(x, 1'b0, '0, 1'b0);
      end
    end

    settle();
    if (decimated_q.size() != 0) begin
      $display("%0t: %0d expected outputs never arrived", $time, decimated_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
